FILE: src/rtlf_pkg.sv
// Shared constants, types and helpers for the RGBA fade engine.
package rtlf_pkg;

    localparam int TIME_BITS  = 16;
    localparam int DELTA_BITS = 16;
    localparam int CHAN_BITS  = 8;
    localparam int COLOUR_BITS = 4 * CHAN_BITS;
    localparam int DUR_BITS   = (TIME_BITS < 16) ? TIME_BITS : 16;
    localparam int SUM_BITS   = ((DUR_BITS > DELTA_BITS) ? DUR_BITS : DELTA_BITS) + 1;
    localparam int PROD_BITS  = CHAN_BITS + DUR_BITS;
    localparam int IDX_BITS   = 3;
    localparam int STEP_BITS  = $clog2(CHAN_BITS);

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_STOP    = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    localparam logic [IDX_BITS-1:0] REG_COLOUR_A  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_COLOUR_B  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_RED_DUR   = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_GREEN_DUR = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_BLUE_DUR  = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_ALPHA_DUR = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;
        logic       calc;
        logic       mul0;
        logic       mul1;
        logic       div_step;
        logic       write;
        logic       last;
        logic [1:0] ch;
        logic       load_out;
    } rtlf_cmd_t;

    typedef struct packed {
        logic active;
    } rtlf_status_t;

    // Channel 0 is red in the top byte, channel 3 alpha in the low byte.
    function automatic logic [CHAN_BITS-1:0] chan_of(
        input logic [COLOUR_BITS-1:0] colour,
        input logic [1:0]             ch
    );
        logic [CHAN_BITS-1:0] val;
        case (ch)
            2'd0:    val = colour[4*CHAN_BITS-1:3*CHAN_BITS];
            2'd1:    val = colour[3*CHAN_BITS-1:2*CHAN_BITS];
            2'd2:    val = colour[2*CHAN_BITS-1:CHAN_BITS];
            default: val = colour[CHAN_BITS-1:0];
        endcase
        return val;
    endfunction

endpackage

FILE: src/rtlf_ifs.sv
// Item channel interfaces: fade commands in, colour results out.
interface rtlf_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       operation;
    logic [rtlf_pkg::DELTA_BITS-1:0]  tick_delta;

    modport source (output valid, output operation, output tick_delta, input ready);
    modport sink   (input valid, input operation, input tick_delta, output ready);
endinterface

interface rtlf_result_if;
    logic                             valid;
    logic                             ready;
    logic [rtlf_pkg::CHAN_BITS-1:0]   out_red;
    logic [rtlf_pkg::CHAN_BITS-1:0]   out_green;
    logic [rtlf_pkg::CHAN_BITS-1:0]   out_blue;
    logic [rtlf_pkg::CHAN_BITS-1:0]   out_alpha;
    logic                             running;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, output running, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_alpha, input running, output ready);
endinterface

FILE: src/rtlf_ctrl.sv
// Sequencer for the fade engine: walks each channel through clamp, multiply and divide.
module rtlf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             operation,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  rtlf_pkg::rtlf_status_t status,
    output rtlf_pkg::rtlf_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CALC   = 3'd1;
    localparam logic [2:0] S_MUL0   = 3'd2;
    localparam logic [2:0] S_MUL1   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]                     state_reg, state_next;
    logic [1:0]                     ch_reg, ch_next;
    logic [rtlf_pkg::STEP_BITS-1:0] step_reg, step_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           accept;
    logic                           slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.ch       = ch_reg;
        cmd.accept   = accept;
        cmd.last     = (ch_reg == 2'd3);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ch_next = 2'd0;
                    if (operation == rtlf_pkg::OP_TICK && status.active)
                        state_next = S_CALC;
                    else
                        state_next = S_FINISH;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_MUL0;
            end
            S_MUL0:
            begin
                cmd.mul0   = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == rtlf_pkg::STEP_BITS'(rtlf_pkg::CHAN_BITS - 1))
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write = 1'b1;
                if (ch_reg == 2'd3)
                    state_next = S_FINISH;
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = S_CALC;
                end
            end
            S_FINISH:
            begin
                // Hold until the output register is free.
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= 2'd0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: src/rtlf_datapath.sv
// Fade datapath: colour and duration registers, per-channel counters, shared mul/div unit.
module rtlf_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rtlf_pkg::IDX_BITS-1:0]        cfg_index,
    input  logic [rtlf_pkg::COLOUR_BITS-1:0]     cfg_wdata,
    input  logic [1:0]                           operation,
    input  logic [rtlf_pkg::DELTA_BITS-1:0]      tick_delta,
    input  rtlf_pkg::rtlf_cmd_t                  cmd,
    output rtlf_pkg::rtlf_status_t               status,
    output logic [rtlf_pkg::CHAN_BITS-1:0]       out_red,
    output logic [rtlf_pkg::CHAN_BITS-1:0]       out_green,
    output logic [rtlf_pkg::CHAN_BITS-1:0]       out_blue,
    output logic [rtlf_pkg::CHAN_BITS-1:0]       out_alpha,
    output logic                                 running
);

    localparam int DB = rtlf_pkg::DUR_BITS;
    localparam int CB = rtlf_pkg::CHAN_BITS;
    localparam int PB = rtlf_pkg::PROD_BITS;
    localparam int SB = rtlf_pkg::SUM_BITS;

    logic [rtlf_pkg::COLOUR_BITS-1:0] colour_a_reg, colour_b_reg;
    logic [DB-1:0]                    dur_reg     [4];
    logic [DB-1:0]                    elapsed_reg [4];
    logic [CB-1:0]                    current_reg [4];
    logic                             active_reg, active_next;
    logic                             done_reg;
    logic [rtlf_pkg::DELTA_BITS-1:0]  delta_reg;
    logic [DB-1:0]                    e_reg;
    logic [PB-1:0]                    acc_reg;
    logic [DB-1:0]                    rem_reg;
    logic [CB-1:0]                    quo_reg;
    logic [CB-1:0]                    red_reg, green_reg, blue_reg, alpha_reg;
    logic                             running_reg;

    logic                             colour_wr;
    logic [rtlf_pkg::COLOUR_BITS-1:0] new_a;
    logic                             op_restart;
    logic [DB-1:0]                    d_cur;
    logic [CB-1:0]                    a_cur, b_cur;
    logic [SB-1:0]                    e_sum;
    logic [DB-1:0]                    e_clamped;
    logic [PB-1:0]                    sum;
    logic [DB:0]                      trial;
    logic [DB:0]                      diff;
    logic                             ge;

    assign colour_wr  = cfg_we && (cfg_index == rtlf_pkg::REG_COLOUR_A ||
                                   cfg_index == rtlf_pkg::REG_COLOUR_B);
    assign new_a      = (cfg_we && cfg_index == rtlf_pkg::REG_COLOUR_A) ? cfg_wdata
                                                                         : colour_a_reg;
    assign op_restart = cmd.accept && operation == rtlf_pkg::OP_RESTART;

    assign d_cur = dur_reg[cmd.ch];
    assign a_cur = rtlf_pkg::chan_of(colour_a_reg, cmd.ch);
    assign b_cur = rtlf_pkg::chan_of(colour_b_reg, cmd.ch);

    // Advance and clamp at the channel's duration.
    assign e_sum     = SB'(elapsed_reg[cmd.ch]) + SB'(delta_reg);
    assign e_clamped = (e_sum > SB'(d_cur)) ? d_cur : e_sum[DB-1:0];

    assign sum   = acc_reg + PB'(a_cur) * PB'(e_reg);
    // One quotient bit per step; the quotient always fits in a channel.
    assign trial = {rem_reg, quo_reg[CB-1]};
    assign diff  = trial - {1'b0, d_cur};
    assign ge    = (trial >= {1'b0, d_cur});

    assign status.active = active_reg;

    always_comb
    begin
        active_next = active_reg;
        if (colour_wr)
            active_next = 1'b0;
        else if (cmd.accept && operation == rtlf_pkg::OP_START)
            active_next = 1'b1;
        else if (cmd.accept && operation == rtlf_pkg::OP_STOP)
            active_next = 1'b0;
        else if (cmd.write && cmd.last && done_reg)
            active_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_a_reg <= '0;
            colour_b_reg <= '0;
            active_reg   <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                dur_reg[i]     <= '0;
                elapsed_reg[i] <= '0;
                current_reg[i] <= '0;
            end
        end
        else
        begin
            active_reg <= active_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    rtlf_pkg::REG_COLOUR_A:  colour_a_reg <= cfg_wdata;
                    rtlf_pkg::REG_COLOUR_B:  colour_b_reg <= cfg_wdata;
                    rtlf_pkg::REG_RED_DUR:   dur_reg[0]   <= cfg_wdata[DB-1:0];
                    rtlf_pkg::REG_GREEN_DUR: dur_reg[1]   <= cfg_wdata[DB-1:0];
                    rtlf_pkg::REG_BLUE_DUR:  dur_reg[2]   <= cfg_wdata[DB-1:0];
                    rtlf_pkg::REG_ALPHA_DUR: dur_reg[3]   <= cfg_wdata[DB-1:0];
                    default: ;
                endcase
            end
            if (colour_wr || op_restart)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    elapsed_reg[i] <= '0;
                    current_reg[i] <= rtlf_pkg::chan_of(new_a, 2'(i));
                end
            end
            if (cmd.calc)
                elapsed_reg[cmd.ch] <= e_clamped;
            if (cmd.write)
                current_reg[cmd.ch] <= (d_cur == '0) ? a_cur : quo_reg;
        end
    end

    // Working registers; no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            delta_reg <= tick_delta;
            done_reg  <= 1'b1;
        end
        if (cmd.calc)
        begin
            e_reg    <= e_clamped;
            done_reg <= done_reg && (e_clamped == d_cur);
        end
        if (cmd.mul0)
            acc_reg <= PB'(b_cur) * PB'(d_cur - e_reg);
        if (cmd.mul1)
        begin
            rem_reg <= sum[PB-1:CB];
            quo_reg <= sum[CB-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? diff[DB-1:0] : trial[DB-1:0];
            quo_reg <= {quo_reg[CB-2:0], ge};
        end
        if (cmd.load_out)
        begin
            red_reg     <= current_reg[0];
            green_reg   <= current_reg[1];
            blue_reg    <= current_reg[2];
            alpha_reg   <= current_reg[3];
            running_reg <= active_reg;
        end
    end

    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign out_alpha = alpha_reg;
    assign running   = running_reg;

endmodule

FILE: src/rgba_timed_linear_fade_top.sv
// Top level of the four-channel RGBA timed linear fade engine.
// Each command item (tick, start, stop, restart) yields one result item with the current
// colour and the running flag. Stop, start, restart and a tick while stopped go from
// acceptance straight to loading the output register. A tick while running is accepted,
// then each of the four channels in turn passes through one shared unit (clamp, two 8x16
// multiplies, a restoring divide that yields one quotient bit per cycle, and a write-back),
// and then the output register is loaded. One item is in flight at a time; the next
// is taken as soon as the result is registered, even if that result has not yet been
// collected.
// Writing colour A or colour B stops the fade and shows colour A; the user must write
// configuration only while the block is idle; the block itself does not enforce this.
module rgba_timed_linear_fade_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rtlf_pkg::IDX_BITS-1:0]        cfg_index,
    input  logic [rtlf_pkg::COLOUR_BITS-1:0]     cfg_wdata,
    rtlf_cmd_if.sink                             cmd,
    rtlf_result_if.source                        result
);

    rtlf_pkg::rtlf_cmd_t    ctl;
    rtlf_pkg::rtlf_status_t status;

    rtlf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .operation (cmd.operation),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (ctl)
    );

    rtlf_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .operation  (cmd.operation),
        .tick_delta (cmd.tick_delta),
        .cmd        (ctl),
        .status     (status),
        .out_red    (result.out_red),
        .out_green  (result.out_green),
        .out_blue   (result.out_blue),
        .out_alpha  (result.out_alpha),
        .running    (result.running)
    );

endmodule

FILE: bench/rgba_timed_linear_fade_top_tb.sv
// Testbench for the RGBA timed linear fade engine: command items checked against a predictor.
`timescale 1ns / 100ps

module rgba_timed_linear_fade_top_tb;

    typedef logic [rtlf_pkg::IDX_BITS-1:0]    idx_t;
    typedef logic [rtlf_pkg::DELTA_BITS-1:0]  delta_t;
    typedef logic [rtlf_pkg::DUR_BITS-1:0]    dur_t;
    typedef logic [1:0]                       op_t;

    localparam idx_t REG_SPARE_LO = 3'd6;
    localparam idx_t REG_SPARE_HI = 3'd7;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 100;
    localparam int STALL_LIMIT = 10000;

    typedef struct packed {
        logic [rtlf_pkg::CHAN_BITS-1:0] red;
        logic [rtlf_pkg::CHAN_BITS-1:0] green;
        logic [rtlf_pkg::CHAN_BITS-1:0] blue;
        logic [rtlf_pkg::CHAN_BITS-1:0] alpha;
        logic                           running;
    } colour_result_t;

    class fade_scoreboard;
        logic [rtlf_pkg::COLOUR_BITS-1:0] colour_a;
        logic [rtlf_pkg::COLOUR_BITS-1:0] colour_b;
        dur_t                             fade_len [4];
        dur_t                             elapsed [4];
        logic [rtlf_pkg::CHAN_BITS-1:0]   shown [4];
        logic                             active;
        colour_result_t                   expected_colours [$];
        int                               mismatches;

        function void clear();
            int ch;
            colour_a = '0;
            colour_b = '0;
            for (ch = 0; ch < 4; ch++)
            begin
                fade_len[ch] = '0;
                elapsed[ch]  = '0;
                shown[ch]    = '0;
            end
            active = 1'b0;
            mismatches = 0;
            expected_colours.delete();
        endfunction

        function void restart_colours();
            int ch;
            for (ch = 0; ch < 4; ch++)
            begin
                elapsed[ch] = '0;
                shown[ch]   = colour_a[8*(3-ch) +: 8];
            end
        endfunction

        function void note_register(idx_t idx, logic [rtlf_pkg::COLOUR_BITS-1:0] data);
            case (idx)
                rtlf_pkg::REG_COLOUR_A, rtlf_pkg::REG_COLOUR_B:
                begin
                    if (idx == rtlf_pkg::REG_COLOUR_A)
                        colour_a = data;
                    else
                        colour_b = data;
                    active = 1'b0;
                    restart_colours();
                end
                rtlf_pkg::REG_RED_DUR:   fade_len[0] = data[rtlf_pkg::DUR_BITS-1:0];
                rtlf_pkg::REG_GREEN_DUR: fade_len[1] = data[rtlf_pkg::DUR_BITS-1:0];
                rtlf_pkg::REG_BLUE_DUR:  fade_len[2] = data[rtlf_pkg::DUR_BITS-1:0];
                rtlf_pkg::REG_ALPHA_DUR: fade_len[3] = data[rtlf_pkg::DUR_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void advance_fade(delta_t delta);
            logic [rtlf_pkg::DELTA_BITS:0] sum;
            dur_t                          e;
            logic [31:0]                   num;
            logic [31:0]                   chan_a;
            logic [31:0]                   chan_b;
            bit                            done;
            int                            ch;
            done = 1'b1;
            for (ch = 0; ch < 4; ch++)
            begin
                sum = {1'b0, elapsed[ch]} + {1'b0, delta};
                e = (sum > {1'b0, fade_len[ch]}) ? fade_len[ch]
                                                 : sum[rtlf_pkg::DUR_BITS-1:0];
                elapsed[ch] = e;
                chan_a = 32'(colour_a[8*(3-ch) +: 8]);
                chan_b = 32'(colour_b[8*(3-ch) +: 8]);
                // Zero length shows colour A at once
                if (fade_len[ch] == '0)
                    shown[ch] = chan_a[7:0];
                else
                begin
                    num = chan_b * 32'(fade_len[ch] - e) + chan_a * 32'(e);
                    shown[ch] = 8'(num / 32'(fade_len[ch]));
                end
                if (e != fade_len[ch])
                    done = 1'b0;
            end
            if (done)
                active = 1'b0;
        endfunction

        function void predict_command(op_t op, delta_t delta);
            case (op)
                rtlf_pkg::OP_TICK:    if (active) advance_fade(delta);
                rtlf_pkg::OP_START:   active = 1'b1;
                rtlf_pkg::OP_STOP:    active = 1'b0;
                rtlf_pkg::OP_RESTART: restart_colours();
                default: ;
            endcase
            expected_colours.push_back({shown[0], shown[1], shown[2], shown[3], active});
        endfunction

        function void check_colour(colour_result_t got);
            colour_result_t want;
            if (expected_colours.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item r=%0d g=%0d b=%0d a=%0d run=%0b",
                             got.red, got.green, got.blue, got.alpha, got.running);
                return;
            end
            want = expected_colours.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result mismatch: expected r=%0d g=%0d b=%0d a=%0d run=%0b",
                             want.red, want.green, want.blue, want.alpha, want.running);
                    $display("                 got      r=%0d g=%0d b=%0d a=%0d run=%0b",
                             got.red, got.green, got.blue, got.alpha, got.running);
                end
            end
        endfunction

        function int pending();
            return expected_colours.size();
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    idx_t                             cfg_index;
    logic [rtlf_pkg::COLOUR_BITS-1:0] cfg_wdata;
    int                               send_idle;
    int                               recv_idle;
    int                               stall_cycles;
    int                               phase;
    fade_scoreboard                   sb = new;

    rtlf_cmd_if    cmd_ch ();
    rtlf_result_if res_ch ();

    rgba_timed_linear_fade_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .result    (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        res_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);

    // Track accepted items, register writes and the stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
                sb.check_colour({res_ch.out_red, res_ch.out_green, res_ch.out_blue,
                                 res_ch.out_alpha, res_ch.running});
            if (cfg_we)
                sb.note_register(cfg_index, cfg_wdata);
            if (cmd_ch.valid && cmd_ch.ready)
                sb.predict_command(cmd_ch.operation, cmd_ch.tick_delta);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_cmd(input op_t op, input delta_t delta);
        while ($urandom_range(99) < send_idle)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.operation  <= op;
        cmd_ch.tick_delta <= delta;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic cfg_write(input idx_t idx, input logic [rtlf_pkg::COLOUR_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic cfg_done();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off until every expected result item has been collected
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_directed();
        send_cmd(rtlf_pkg::OP_TICK, 16'hFFFF);
        send_cmd(rtlf_pkg::OP_START, 16'h0000);
        send_cmd(rtlf_pkg::OP_TICK, 16'h0000);
        send_cmd(rtlf_pkg::OP_STOP, 16'hFFFF);
        drain();
        cfg_write(rtlf_pkg::REG_RED_DUR, 32'd1);
        cfg_write(rtlf_pkg::REG_GREEN_DUR, 32'd2);
        cfg_write(rtlf_pkg::REG_BLUE_DUR, 32'h0000_FFFF);
        cfg_write(rtlf_pkg::REG_ALPHA_DUR, 32'd0);
        cfg_write(rtlf_pkg::REG_COLOUR_B, 32'h0000_0000);
        cfg_write(rtlf_pkg::REG_COLOUR_A, 32'hFFFF_FFFF);
        cfg_done();
        send_cmd(rtlf_pkg::OP_START, 16'h0000);
        send_cmd(rtlf_pkg::OP_TICK, 16'h0000);
        send_cmd(rtlf_pkg::OP_TICK, 16'h0001);
        send_cmd(rtlf_pkg::OP_TICK, 16'h0001);
        // Restart keeps the fade running
        send_cmd(rtlf_pkg::OP_RESTART, 16'h0000);
        send_cmd(rtlf_pkg::OP_TICK, 16'h8000);
        send_cmd(rtlf_pkg::OP_TICK, 16'hFFFF);
        // Start with every channel already finished
        send_cmd(rtlf_pkg::OP_START, 16'h0000);
        send_cmd(rtlf_pkg::OP_TICK, 16'h7FFF);
        send_cmd(rtlf_pkg::OP_RESTART, 16'hFFFF);
        send_cmd(rtlf_pkg::OP_START, 16'h0000);
        send_cmd(rtlf_pkg::OP_TICK, 16'h5555);
        send_cmd(rtlf_pkg::OP_STOP, 16'h0000);
        send_cmd(rtlf_pkg::OP_TICK, 16'hAAAA);
        send_cmd(rtlf_pkg::OP_START, 16'h0000);
        send_cmd(rtlf_pkg::OP_TICK, 16'h0001);
        drain();
        cfg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
        cfg_write(REG_SPARE_HI, 32'h5A5A_A5A5);
        cfg_write(rtlf_pkg::REG_COLOUR_A, 32'h0000_0000);
        cfg_write(rtlf_pkg::REG_COLOUR_B, 32'hFFFF_FFFF);
        cfg_done();
        send_cmd(rtlf_pkg::OP_TICK, 16'h0001);
        send_cmd(rtlf_pkg::OP_START, 16'h0000);
        send_cmd(rtlf_pkg::OP_TICK, 16'h1234);
    endtask

    task automatic configure_phase(input int ph);
        logic [rtlf_pkg::COLOUR_BITS-1:0] ca;
        logic [rtlf_pkg::COLOUR_BITS-1:0] cb;
        dur_t                             len;
        int                               ch;
        ca = $urandom;
        cb = $urandom;
        if (ph == 0)
        begin
            ca = '1;
            cb = '0;
        end
        else if (ph == 1)
        begin
            ca = '0;
            cb = '1;
        end
        for (ch = 0; ch < 4; ch++)
        begin
            // Mostly short fades so that ticks reach the end
            case ($urandom_range(9))
                0:       len = '0;
                1:       len = '1;
                2, 3:    len = dur_t'($urandom);
                default: len = dur_t'($urandom_range(1, 200));
            endcase
            if (ph == 2)
                len = '1;
            else if (ph == 3)
                len = '0;
            cfg_write(idx_t'(rtlf_pkg::REG_RED_DUR + ch), 32'(len));
        end
        if ($urandom_range(1) == 1)
            cfg_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
        // Leave the colours alone now and then so new lengths clamp running counters
        if (ph < 4 || $urandom_range(2) != 0)
        begin
            cfg_write(rtlf_pkg::REG_COLOUR_B, cb);
            cfg_write(rtlf_pkg::REG_COLOUR_A, ca);
        end
        cfg_done();
    endtask

    task automatic run_random(input int count);
        delta_t delta;
        int     sent;
        int     n;
        int     k;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(3) != 0)
            begin
                send_cmd(rtlf_pkg::OP_RESTART, delta_t'($urandom));
                sent++;
            end
            send_cmd(rtlf_pkg::OP_START, delta_t'($urandom));
            sent++;
            n = $urandom_range(1, 16);
            for (k = 0; k < n; k++)
            begin
                case ($urandom_range(9))
                    0:       delta = '0;
                    1:       delta = '1;
                    2:       delta = delta_t'($urandom);
                    default: delta = delta_t'($urandom_range(1, 40));
                endcase
                if ($urandom_range(9) == 0)
                    send_cmd(op_t'($urandom_range(rtlf_pkg::OP_RESTART, rtlf_pkg::OP_TICK)),
                             delta_t'($urandom));
                else
                    send_cmd(rtlf_pkg::OP_TICK, delta);
                sent++;
            end
        end
    endtask

    initial
    begin
        sb.clear();
        send_idle = 20;
        recv_idle = 86;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= rtlf_pkg::REG_COLOUR_A;
        cfg_wdata         <= '0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.operation  <= rtlf_pkg::OP_TICK;
        cmd_ch.tick_delta <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase < PHASES / 3)
            begin
                send_idle = 20;
                recv_idle = 86;
            end
            else if (phase < 2 * PHASES / 3)
            begin
                send_idle = 86;
                recv_idle = 20;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            drain();
            configure_phase(phase);
            run_random(PHASE_ITEMS);
        end
        drain();
        repeat (60) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
